// ===== design/rkhd_pkg.sv =====
// Shared types and constants for the recent key history duplicate check unit.
`default_nettype none

package rkhd_pkg;

    localparam int DEPTH     = 12;
    localparam int KEY_CHARS = 6;
    localparam int KEY_W     = 48;
    localparam int CNT_OUT_W = 4;

    localparam int KEY_BITS = 8 * KEY_CHARS;
    localparam int IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W    = $clog2(DEPTH + 1);

    localparam logic [KEY_W-1:0] KEY_MASK =
        (KEY_BITS >= KEY_W) ? {KEY_W{1'b1}} : ((KEY_W'(1) << KEY_BITS) - KEY_W'(1));

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_CHECK = 1'b1;

    typedef struct packed {
        logic             operation;
        logic [KEY_W-1:0] key;
    } req_t;

    typedef struct packed {
        logic                 duplicate;
        logic [CNT_OUT_W-1:0] stored_count;
    } rsp_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        logic [KEY_W-1:0] data;
    } mem_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

endpackage

`default_nettype wire

// ===== design/rkhd_hist_mem.sv =====
// History memory with one write port and one registered read port.
`default_nettype none

module rkhd_hist_mem (
    input  wire                        clk,
    input  wire rkhd_pkg::mem_wr_t     wr,
    input  wire rkhd_pkg::mem_rd_t     rd,
    output logic [rkhd_pkg::KEY_W-1:0] rd_data
);

    logic [rkhd_pkg::KEY_W-1:0] mem [rkhd_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr] <= wr.data;
        end
        if (rd.en)
        begin
            rd_data <= mem[rd.addr];
        end
    end

endmodule

`default_nettype wire

// ===== design/recent_key_history_dedup_unit.sv =====
// Top level of the recent key history duplicate check unit with its scan sequencer.
// A load item goes from idle straight to the finish state; a check item first scans the valid
// entries from the oldest one and stops at the first match or after the last valid entry.
// The result is registered in the finish state, which waits while the output is stalled.
// The next item is taken only once the unit is back in idle after the result is registered.
// Reset empties the history and clears the entry count and both indexes.
`default_nettype none

module recent_key_history_dedup_unit (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 req_valid,
    output logic                req_stall,
    input  wire rkhd_pkg::req_t req_data,
    output logic                rsp_valid,
    input  wire                 rsp_stall,
    output rkhd_pkg::rsp_t      rsp_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FINISH
    } state_t;

    state_t                          state_reg;
    logic                            op_reg;
    logic [rkhd_pkg::KEY_W-1:0]      key_reg;
    logic [rkhd_pkg::IDX_W-1:0]      pos_reg;
    logic [rkhd_pkg::CNT_W-1:0]      issued_reg;
    logic                            cmp_vld_reg;
    logic                            dup_reg;
    logic [rkhd_pkg::IDX_W-1:0]      oldest_reg;
    logic [rkhd_pkg::IDX_W-1:0]      next_idx_reg;
    logic [rkhd_pkg::CNT_W-1:0]      count_reg;
    logic                            rsp_valid_reg;
    rkhd_pkg::rsp_t                  rsp_data_reg;

    rkhd_pkg::mem_wr_t               mem_wr;
    rkhd_pkg::mem_rd_t               mem_rd;
    logic [rkhd_pkg::KEY_W-1:0]      mem_rd_data;

    logic                            req_xfer;
    logic                            hit;
    logic                            all_issued;
    logic                            out_free;
    logic                            finish_xfer;
    logic                            append;
    logic                            full;
    logic [rkhd_pkg::CNT_W-1:0]      count_next;

    function automatic logic [rkhd_pkg::IDX_W-1:0] wrap_inc(input logic [rkhd_pkg::IDX_W-1:0] p);
        logic [rkhd_pkg::IDX_W-1:0] r;
        if (p == rkhd_pkg::IDX_W'(rkhd_pkg::DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + rkhd_pkg::IDX_W'(1);
        end
        return r;
    endfunction

    assign req_stall   = (state_reg != S_IDLE);
    assign req_xfer    = req_valid && !req_stall;
    assign hit         = cmp_vld_reg && (mem_rd_data == key_reg);
    assign all_issued  = (issued_reg == count_reg);
    assign out_free    = !rsp_valid_reg || !rsp_stall;
    assign full        = (count_reg == rkhd_pkg::CNT_W'(rkhd_pkg::DEPTH));
    assign finish_xfer = (state_reg == S_FINISH) && out_free;
    assign append      = finish_xfer && !dup_reg;
    assign count_next  = full ? count_reg : count_reg + rkhd_pkg::CNT_W'(1);

    always_comb
    begin
        mem_rd.en   = (state_reg == S_SCAN) && !all_issued;
        mem_rd.addr = pos_reg;
        mem_wr.en   = append;
        mem_wr.addr = next_idx_reg;
        mem_wr.data = key_reg;
    end

    rkhd_hist_mem u_mem (
        .clk     (clk),
        .wr      (mem_wr),
        .rd      (mem_rd),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= rkhd_pkg::OP_LOAD;
            key_reg       <= '0;
            pos_reg       <= '0;
            issued_reg    <= '0;
            cmp_vld_reg   <= 1'b0;
            dup_reg       <= 1'b0;
            oldest_reg    <= '0;
            next_idx_reg  <= '0;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else
        begin
            if (rsp_valid_reg && !rsp_stall && !finish_xfer)
            begin
                rsp_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (req_xfer)
                    begin
                        op_reg      <= req_data.operation;
                        key_reg     <= req_data.key & rkhd_pkg::KEY_MASK;
                        pos_reg     <= oldest_reg;
                        issued_reg  <= '0;
                        cmp_vld_reg <= 1'b0;
                        dup_reg     <= 1'b0;
                        if (req_data.operation == rkhd_pkg::OP_CHECK)
                        begin
                            state_reg <= S_SCAN;
                        end
                        else
                        begin
                            state_reg <= S_FINISH;
                        end
                    end
                end
                S_SCAN:
                begin
                    cmp_vld_reg <= !all_issued;
                    if (!all_issued)
                    begin
                        pos_reg    <= wrap_inc(pos_reg);
                        issued_reg <= issued_reg + rkhd_pkg::CNT_W'(1);
                    end
                    if (hit)
                    begin
                        dup_reg   <= 1'b1;
                        state_reg <= S_FINISH;
                    end
                    else if (all_issued && !cmp_vld_reg)
                    begin
                        state_reg <= S_FINISH;
                    end
                end
                S_FINISH:
                begin
                    if (out_free)
                    begin
                        rsp_valid_reg             <= 1'b1;
                        rsp_data_reg.duplicate    <= dup_reg;
                        if (append)
                        begin
                            count_reg    <= count_next;
                            next_idx_reg <= wrap_inc(next_idx_reg);
                            if (full)
                            begin
                                oldest_reg <= wrap_inc(oldest_reg);
                            end
                            rsp_data_reg.stored_count <= rkhd_pkg::CNT_OUT_W'(count_next);
                        end
                        else
                        begin
                            rsp_data_reg.stored_count <= rkhd_pkg::CNT_OUT_W'(count_reg);
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp_data  = rsp_data_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= rkhd_pkg::CNT_W'(rkhd_pkg::DEPTH))
        else $error("Entry count exceeds the history depth.");

    a_full_ring: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> (oldest_reg == next_idx_reg))
        else $error("Full history with oldest and next positions apart.");

    a_oldest_fixed: assert property (@(posedge clk) disable iff (!rst_n)
        !full |-> (oldest_reg == '0))
        else $error("Oldest position moved before the history filled.");

    a_load_no_dup: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == S_FINISH) && (op_reg == rkhd_pkg::OP_LOAD)) |-> !dup_reg)
        else $error("Load item flagged as duplicate.");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> (issued_reg <= count_reg))
        else $error("Scan issued more reads than valid entries.");

endmodule

`default_nettype wire
